// File: hdl/sorted_separator_node_table_macros.svh
// Assertion macros for the sorted separator node table.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef SORTED_SEPARATOR_NODE_TABLE_MACROS_SVH
`define SORTED_SEPARATOR_NODE_TABLE_MACROS_SVH

// plain property, sampled on clk_i, off during reset
`define SSTAB_AST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// same-cycle implication
`define SSTAB_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/sstab_pkg.sv
// Shared types and constants of the sorted separator node table.
// No dependencies; used by the cell, the select tree and the top level.
package sstab_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam int KEY_W       = 40;
  localparam int QKEY_W      = 64;
  localparam int CHILD_W     = 32;
  localparam int ACT_W       = 2;
  localparam int RIDX_W      = 8;
  localparam int STAT_W      = 3;
  localparam int SLOT_W      = 9;
  localparam int CNT_OUT_W   = 9;

  localparam logic [QKEY_W-1:0] KEY_LIMIT = QKEY_W'((65'd1 << KEY_W) - 65'd1);

  // select tree: groups of GRP cells, then one level over the groups
  localparam int GRP    = 16;
  localparam int GRP_W  = $clog2(GRP);
  localparam int NGRP   = (MAX_ENTRIES + GRP - 1) / GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SEL_W  = NGRP_W + GRP_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_WIDE  = 3'd1,
    ST_FULL  = 3'd2,
    ST_DUP   = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_L1   = 5'b00100,
    S_L2   = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;   // register key compare
    logic ins;   // shift up / place new entry
  } cell_ctl_t;

endpackage

// File: hdl/sorted_separator_node_table.sv
// Steps per transfer: compare, two select-tree levels, finish, and the
// result cycle with strobe done_o, in which the next transfer can already be
// accepted; no new transfer is taken while busy before that.
// The steps come from the registered compare in every cell and the
// two registered levels of the select tree; inserts shift in the finish step.
// Reset (rst_ni low, async) clears the fill count, leftmost child and FSM;
// entry contents are not cleared. Results cannot be stalled.
`include "sorted_separator_node_table_macros.svh"

module sorted_separator_node_table import sstab_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [QKEY_W-1:0]    key_i,
  input  logic [CHILD_W-1:0]   child_page_i,
  input  logic [RIDX_W-1:0]    index_i,
  input  logic                 cfg_we_i,
  input  logic [CHILD_W-1:0]   cfg_wdata_i,
  output logic                 done_o,
  output logic [STAT_W-1:0]    status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [CHILD_W-1:0]   child_out_o,
  output logic [KEY_W-1:0]     key_out_o,
  output logic [CNT_OUT_W-1:0] fill_count_o
);

  state_e             state_q, state_d;
  act_e               act_q;
  logic [QKEY_W-1:0]  key_q;
  logic [CHILD_W-1:0] child_q;
  logic [RIDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CHILD_W-1:0] left_q;

  status_e            status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CHILD_W-1:0] cout_q, cout_d;
  logic [KEY_W-1:0]   kout_q, kout_d;
  logic               done_q, done_d;

  logic               accept;
  cell_ctl_t          ctl;
  logic               ins_go;

  logic [KEY_W-1:0]   cell_key   [MAX_ENTRIES];
  logic [CHILD_W-1:0] cell_child [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] le_used, live, hit;

  logic               sel_any;
  logic [IDX_W-1:0]   sel_idx;
  logic [KEY_W-1:0]   sel_key;
  logic [CHILD_W-1:0] sel_child;

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  // ---- cell row ----
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0]   prev_key;
    logic [CHILD_W-1:0] prev_child;
    logic               prev_le, next_le;

    if (i == 0) begin : g_first
      assign prev_key   = '0;
      assign prev_child = '0;
      assign prev_le    = 1'b1;
    end else begin : g_mid
      assign prev_key   = cell_key[i-1];
      assign prev_child = cell_child[i-1];
      assign prev_le    = le_used[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign next_le = 1'b0;
    end else begin : g_inner
      assign next_le = le_used[i+1];
    end

    assign live[i] = (CNT_W'(i) < used_q);
    // lookup boundary, or the addressed entry for a read
    assign hit[i]  = (act_q == ACT_READ) ? ((32'(idx_q) == 32'(i)) & live[i])
                                         : (le_used[i] & ~next_le);

    sstab_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .qkey_i       (key_q),
      .new_child_i  (child_q),
      .prev_key_i   (prev_key),
      .prev_child_i (prev_child),
      .prev_le_i    (prev_le),
      .live_i       (live[i]),
      .key_o        (cell_key[i]),
      .child_o      (cell_child[i]),
      .le_o         (le_used[i])
    );
  end

  sstab_select u_select (
    .clk_i   (clk_i),
    .hit_i   (hit),
    .key_i   (cell_key),
    .child_i (cell_child),
    .any_o   (sel_any),
    .idx_o   (sel_idx),
    .key_o   (sel_key),
    .child_o (sel_child)
  );

  // ---- finish step ----
  logic             key_wide, tab_full, dup;
  logic [CNT_W-1:0] ins_pos;

  always_comb begin
    key_wide = (key_q > KEY_LIMIT);
    tab_full = (used_q >= CNT_W'(MAX_ENTRIES));
    dup      = sel_any & (sel_key == key_q[KEY_W-1:0]);
    ins_pos  = sel_any ? (CNT_W'(sel_idx) + CNT_W'(1)) : '0;
    ins_go   = (state_q == S_FIN) & (act_q == ACT_INSERT) & ~key_wide & ~tab_full & ~dup;
    ctl.cmp  = (state_q == S_CMP);
    ctl.ins  = ins_go;
  end

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    done_d   = 1'b0;
    status_d = status_q;
    slot_d   = slot_q;
    cout_d   = cout_q;
    kout_d   = kout_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_CMP;
      S_CMP:  state_d = S_L1;
      S_L1:   state_d = S_L2;
      S_L2:   state_d = S_FIN;
      S_FIN: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = ST_OK;
        slot_d   = '1;
        cout_d   = '0;
        kout_d   = '0;
        unique case (act_q)
          ACT_LOOKUP: begin
            if (sel_any) begin
              slot_d = SLOT_W'(sel_idx);
              cout_d = sel_child;
            end else begin
              cout_d = left_q;
            end
          end
          ACT_INSERT: begin
            priority if (key_wide) begin
              status_d = ST_WIDE;
            end else if (tab_full) begin
              status_d = ST_FULL;
            end else if (dup) begin
              status_d = ST_DUP;
              slot_d   = SLOT_W'(sel_idx);
            end else begin
              slot_d = SLOT_W'(ins_pos);
              used_d = used_q + CNT_W'(1);
            end
          end
          ACT_READ: begin
            if (sel_any) begin
              slot_d = SLOT_W'(sel_idx);
              cout_d = sel_child;
              kout_d = sel_key;
            end else begin
              status_d = ST_RANGE;
            end
          end
          ACT_CLEAR: used_d = '0;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      left_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (cfg_we_i) left_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= act_e'(action_i);
      key_q   <= key_i;
      child_q <= child_page_i;
      idx_q   <= index_i;
    end
    status_q <= status_d;
    slot_q   <= slot_d;
    cout_q   <= cout_d;
    kout_q   <= kout_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign child_out_o  = cout_q;
  assign key_out_o    = kout_q;
  assign fill_count_o = CNT_OUT_W'(used_q);

  // ---- assertions ----
  `SSTAB_AST_IMP(a_done_idle, done_o, !busy, "result strobe while busy")
  `SSTAB_AST(a_done_lat, (start && !busy) |-> ##5 done_o, "result missing 5 cycles after start")
  `SSTAB_AST_IMP(a_hit_onehot, state_q == S_L1, $onehot0(hit), "more than one cell selected")
  `SSTAB_AST(a_cnt_bound, used_q <= CNT_W'(MAX_ENTRIES), "entry count past table size")
  `SSTAB_AST(a_ins_cnt, ins_go |=> used_q == CNT_W'($past(used_q) + CNT_W'(1)), "insert lost count")

endmodule

// File: hdl/sstab_cell.sv
// One slot of the separator table: key, child page and the compare flag.
// Depends on sstab_pkg; shifts from its lower neighbor on insert.
module sstab_cell import sstab_pkg::*; (
  input  logic               clk_i,
  input  cell_ctl_t          ctl_i,
  input  logic [QKEY_W-1:0]  qkey_i,
  input  logic [CHILD_W-1:0] new_child_i,
  input  logic [KEY_W-1:0]   prev_key_i,
  input  logic [CHILD_W-1:0] prev_child_i,
  input  logic               prev_le_i,
  input  logic               live_i,
  output logic [KEY_W-1:0]   key_o,
  output logic [CHILD_W-1:0] child_o,
  output logic               le_o
);

  logic [KEY_W-1:0]   key_q, key_d;
  logic [CHILD_W-1:0] child_q, child_d;
  logic               le_q;
  logic               take_prev, take_new;

  assign le_o = le_q & live_i;

  // sorted table: cells at or below the insert point keep, the one above
  // the last "<=" cell takes the new entry, the rest take their neighbor
  always_comb begin
    take_prev = ctl_i.ins & ~prev_le_i;
    take_new  = ctl_i.ins & prev_le_i & ~le_o;
    key_d     = key_q;
    child_d   = child_q;
    priority if (take_new) begin
      key_d   = qkey_i[KEY_W-1:0];
      child_d = new_child_i;
    end else if (take_prev) begin
      key_d   = prev_key_i;
      child_d = prev_child_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    child_q <= child_d;
    if (ctl_i.cmp) begin
      le_q <= (QKEY_W'(key_q) <= qkey_i);
    end
  end

  assign key_o   = key_q;
  assign child_o = child_q;

endmodule

// File: hdl/sstab_select.sv
// Two-level registered select tree: picks the one flagged cell's index,
// key and child. Depends on sstab_pkg. Both levels registered, no enables.
module sstab_select import sstab_pkg::*; (
  input  logic               clk_i,
  input  logic [MAX_ENTRIES-1:0] hit_i,
  input  logic [KEY_W-1:0]   key_i   [MAX_ENTRIES],
  input  logic [CHILD_W-1:0] child_i [MAX_ENTRIES],
  output logic               any_o,
  output logic [IDX_W-1:0]   idx_o,
  output logic [KEY_W-1:0]   key_o,
  output logic [CHILD_W-1:0] child_o
);

  localparam int PAD = NGRP * GRP;

  logic               hit_pad   [PAD];
  logic [KEY_W-1:0]   key_pad   [PAD];
  logic [CHILD_W-1:0] child_pad [PAD];

  for (genvar k = 0; k < PAD; k++) begin : g_pad
    if (k < MAX_ENTRIES) begin : g_real
      assign hit_pad[k]   = hit_i[k];
      assign key_pad[k]   = key_i[k];
      assign child_pad[k] = child_i[k];
    end else begin : g_fill
      assign hit_pad[k]   = 1'b0;
      assign key_pad[k]   = '0;
      assign child_pad[k] = '0;
    end
  end

  // level 1: per group
  logic               g_any_d   [NGRP];
  logic [GRP_W-1:0]   g_loc_d   [NGRP];
  logic [KEY_W-1:0]   g_key_d   [NGRP];
  logic [CHILD_W-1:0] g_child_d [NGRP];
  logic               g_any_q   [NGRP];
  logic [GRP_W-1:0]   g_loc_q   [NGRP];
  logic [KEY_W-1:0]   g_key_q   [NGRP];
  logic [CHILD_W-1:0] g_child_q [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      g_any_d[g]   = 1'b0;
      g_loc_d[g]   = '0;
      g_key_d[g]   = '0;
      g_child_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (hit_pad[g*GRP + j]) begin
          g_any_d[g]   = 1'b1;
          g_loc_d[g]   = g_loc_d[g] | GRP_W'(j);
          g_key_d[g]   = g_key_d[g] | key_pad[g*GRP + j];
          g_child_d[g] = g_child_d[g] | child_pad[g*GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    g_any_q   <= g_any_d;
    g_loc_q   <= g_loc_d;
    g_key_q   <= g_key_d;
    g_child_q <= g_child_d;
  end

  // level 2: over the groups
  logic               any_d, any_q;
  logic [SEL_W-1:0]   sel_d, sel_q;
  logic [KEY_W-1:0]   key_d, key_q;
  logic [CHILD_W-1:0] child_d, child_q;

  always_comb begin
    any_d   = 1'b0;
    sel_d   = '0;
    key_d   = '0;
    child_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (g_any_q[g]) begin
        any_d   = 1'b1;
        sel_d   = sel_d | {NGRP_W'(g), g_loc_q[g]};
        key_d   = key_d | g_key_q[g];
        child_d = child_d | g_child_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    any_q   <= any_d;
    sel_q   <= sel_d;
    key_q   <= key_d;
    child_q <= child_d;
  end

  assign any_o   = any_q;
  assign idx_o   = IDX_W'(sel_q);
  assign key_o   = key_q;
  assign child_o = child_q;

endmodule

// File: bench/sorted_separator_node_table_tb.sv
// Self-checking bench for sorted_separator_node_table: directed rows, then random phases.
// Depends on sstab_pkg for widths and codes; predicts results with its own table copy, typed rows carry their own.
`timescale 1ns / 100ps

module sorted_separator_node_table_tb;
  import sstab_pkg::*;

  localparam int RAND_ITEMS = 1850;
  localparam logic [SLOT_W-1:0] NO_SLOT = 9'h1FF;

  typedef struct packed {
    status_e                status;
    logic [SLOT_W-1:0]      slot;
    logic [CHILD_W-1:0]     child;
    logic [KEY_W-1:0]       key;
    logic [CNT_OUT_W-1:0]   count;
  } node_result_t;

  typedef struct {
    act_e               act;
    logic [QKEY_W-1:0]  key;
    logic [CHILD_W-1:0] child;
    logic [RIDX_W-1:0]  idx;
    bit                 typed;
    node_result_t       res;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ACT_W-1:0]     action_i = '0;
  logic [QKEY_W-1:0]    key_i = '0;
  logic [CHILD_W-1:0]   child_page_i = '0;
  logic [RIDX_W-1:0]    index_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CHILD_W-1:0]   cfg_wdata_i = '0;
  logic                 done_o;
  logic [STAT_W-1:0]    status_o;
  logic [SLOT_W-1:0]    slot_o;
  logic [CHILD_W-1:0]   child_out_o;
  logic [KEY_W-1:0]     key_out_o;
  logic [CNT_OUT_W-1:0] fill_count_o;

  sorted_separator_node_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .key_i         (key_i),
    .child_page_i  (child_page_i),
    .index_i       (index_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .child_out_o   (child_out_o),
    .key_out_o     (key_out_o),
    .fill_count_o  (fill_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // bench copy of the node table
  logic [KEY_W-1:0]   tbl_keys  [MAX_ENTRIES];
  logic [CHILD_W-1:0] tbl_child [MAX_ENTRIES];
  int                 tbl_used = 0;
  logic [CHILD_W-1:0] leftmost_pg = '0;

  node_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  node_result_t no_res;
  node_result_t mon_want;
  bit           mon_ok;
  int           err_count = 0;
  int           sent_items = 0;
  int           hold_gap = 1;
  int           gap_mode = 1;

  function automatic node_result_t result_of(status_e s, logic [SLOT_W-1:0] sl,
                                             logic [CHILD_W-1:0] c, logic [KEY_W-1:0] k,
                                             logic [CNT_OUT_W-1:0] n);
    node_result_t r;
    r.status = s;
    r.slot   = sl;
    r.child  = c;
    r.key    = k;
    r.count  = n;
    return r;
  endfunction

  // entries with separator <= k, compared over the full 64-bit key
  function automatic int count_le(logic [QKEY_W-1:0] k);
    int n;
    int i;
    n = 0;
    for (i = 0; i < tbl_used; i++) begin
      if ({24'd0, tbl_keys[i]} <= k) n = i + 1;
      else break;
    end
    return n;
  endfunction

  function automatic node_result_t node_table_apply(act_e act, logic [QKEY_W-1:0] k,
                                                    logic [CHILD_W-1:0] ch,
                                                    logic [RIDX_W-1:0] ix);
    node_result_t r;
    int n;
    int i;
    r = result_of(ST_OK, NO_SLOT, '0, '0, '0);
    case (act)
      ACT_LOOKUP: begin
        n = count_le(k);
        r.slot  = SLOT_W'(n - 1);
        r.child = (n == 0) ? leftmost_pg : tbl_child[n-1];
      end
      ACT_INSERT: begin
        if (k > KEY_LIMIT) begin
          r.status = ST_WIDE;
        end else if (tbl_used >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          n = count_le(k);
          if (n > 0 && tbl_keys[n-1] == k[KEY_W-1:0]) begin
            r.status = ST_DUP;
            r.slot   = SLOT_W'(n - 1);
          end else begin
            for (i = tbl_used; i > n; i--) begin
              tbl_keys[i]  = tbl_keys[i-1];
              tbl_child[i] = tbl_child[i-1];
            end
            tbl_keys[n]  = k[KEY_W-1:0];
            tbl_child[n] = ch;
            tbl_used++;
            r.slot = SLOT_W'(n);
          end
        end
      end
      ACT_READ: begin
        if (int'(ix) >= tbl_used) begin
          r.status = ST_RANGE;
        end else begin
          r.slot  = {1'b0, ix};
          r.child = tbl_child[ix];
          r.key   = tbl_keys[ix];
        end
      end
      default: tbl_used = 0;
    endcase
    r.count = CNT_OUT_W'(tbl_used);
    return r;
  endfunction

  function automatic int draw_gap();
    case (gap_mode)
      0:       return 0;
      1:       return $urandom_range(0, 14);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    endcase
  endfunction

  // start stays high across back-to-back transfers; a gap or park() lowers it
  task automatic send_item(act_e act, logic [QKEY_W-1:0] k, logic [CHILD_W-1:0] ch,
                           logic [RIDX_W-1:0] ix, bit typed, node_result_t typed_res);
    node_result_t r;
    repeat (hold_gap) @(posedge clk_i);
    start        <= 1'b1;
    action_i     <= act;
    key_i        <= k;
    child_page_i <= ch;
    index_i      <= ix;
    do @(posedge clk_i); while (busy);
    r = node_table_apply(act, k, ch, ix);
    pending_results.push_back(typed ? typed_res : r);
    sent_items++;
    hold_gap = draw_gap();
    if (hold_gap != 0) start <= 1'b0;
  endtask

  task automatic park();
    if (hold_gap == 0) start <= 1'b0;
    hold_gap = 1;
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic random_item();
    logic [QKEY_W-1:0] k;
    logic [RIDX_W-1:0] ix;
    act_e act;
    int r;
    r = $urandom_range(0, 99);
    act = (r < 40) ? ACT_INSERT : (r < 70) ? ACT_LOOKUP : (r < 95) ? ACT_READ : ACT_CLEAR;
    r = $urandom_range(0, 9);
    if (r <= 2 && tbl_used > 0) begin
      // near an existing separator: hits, duplicates and neighbors
      k = {24'd0, tbl_keys[$urandom_range(0, tbl_used - 1)]} + 64'($urandom_range(0, 2)) - 64'd1;
    end else if (r <= 5) begin
      k = 64'($urandom_range(0, 31));
    end else if (r <= 7) begin
      k = {$urandom, $urandom} & KEY_LIMIT;
    end else if (r == 8) begin
      k = {$urandom, $urandom};
    end else begin
      case ($urandom_range(0, 3))
        0:       k = '0;
        1:       k = KEY_LIMIT;
        2:       k = KEY_LIMIT + 64'd1;
        default: k = '1;
      endcase
    end
    r = $urandom_range(0, 9);
    if (r <= 6 && tbl_used > 0) ix = RIDX_W'($urandom_range(0, tbl_used - 1));
    else if (r <= 8) ix = RIDX_W'($urandom);
    else ix = (tbl_used > 255) ? 8'd255 : RIDX_W'(tbl_used);
    send_item(act, k, $urandom, ix, 1'b0, no_res);
  endtask

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (want === got) return 1'b1;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  // results cannot be held off: check each strobe against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, expected none, actual status %0h",
                 $time, status_o);
        err_count++;
      end else begin
        mon_want = pending_results.pop_front();
        mon_ok = field_ok("status", 64'(mon_want.status), 64'(status_o))
               & field_ok("slot", 64'(mon_want.slot), 64'(slot_o))
               & field_ok("child_out", 64'(mon_want.child), 64'(child_out_o))
               & field_ok("key_out", 64'(mon_want.key), 64'(key_out_o))
               & field_ok("fill_count", 64'(mon_want.count), 64'(fill_count_o));
        if (!mon_ok) err_count++;
      end
    end
  end

  initial begin
    #(4_000_000);
    $display("sorted_separator_node_table_tb: FAIL");
    $finish;
  end

  initial begin
    int phase;
    int n;
    logic [CHILD_W-1:0] cfg_val;
    no_res = result_of(ST_OK, '0, '0, '0, '0);

    // extremes, every action and each error code but ST_FULL; typed where obvious
    dir_rows.push_back('{ACT_LOOKUP, 64'd0, 32'd0, 8'd0, 1'b1,
                         result_of(ST_OK, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd0, 1'b1,
                         result_of(ST_RANGE, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_CLEAR, '1, '1, '1, 1'b1,
                         result_of(ST_OK, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_INSERT, KEY_LIMIT + 64'd1, '1, 8'd0, 1'b1,
                         result_of(ST_WIDE, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_INSERT, '1, '1, 8'd0, 1'b1,
                         result_of(ST_WIDE, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_INSERT, KEY_LIMIT, '1, 8'd0, 1'b1,
                         result_of(ST_OK, 9'd0, 32'd0, 40'd0, 9'd1)});
    dir_rows.push_back('{ACT_INSERT, 64'd0, 32'd0, 8'd0, 1'b1,
                         result_of(ST_OK, 9'd0, 32'd0, 40'd0, 9'd2)});
    dir_rows.push_back('{ACT_INSERT, 64'd0, 32'h1234, 8'd0, 1'b1,
                         result_of(ST_DUP, 9'd0, 32'd0, 40'd0, 9'd2)});
    dir_rows.push_back('{ACT_INSERT, KEY_LIMIT, 32'd7, 8'd0, 1'b1,
                         result_of(ST_DUP, 9'd1, 32'd0, 40'd0, 9'd2)});
    dir_rows.push_back('{ACT_INSERT, 64'h55_5555_5555, 32'hA5A5_A5A5, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_INSERT, 64'hAA_AAAA_AAAA, 32'h5A5A_5A5A, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_LOOKUP, '1, 32'd0, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_LOOKUP, KEY_LIMIT, 32'd0, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_LOOKUP, KEY_LIMIT - 64'd1, 32'd0, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_LOOKUP, 64'h55_5555_5554, 32'd0, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_LOOKUP, KEY_LIMIT + 64'd1, 32'd0, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd3, 1'b0, no_res});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd4, 1'b1,
                         result_of(ST_RANGE, NO_SLOT, 32'd0, 40'd0, 9'd4)});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd255, 1'b1,
                         result_of(ST_RANGE, NO_SLOT, 32'd0, 40'd0, 9'd4)});
    dir_rows.push_back('{ACT_INSERT, 64'd1, 32'd1, 8'd0, 1'b0, no_res});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd1, 1'b0, no_res});
    dir_rows.push_back('{ACT_CLEAR, 64'd0, 32'd0, 8'd0, 1'b1,
                         result_of(ST_OK, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_LOOKUP, KEY_LIMIT, 32'd0, 8'd0, 1'b1,
                         result_of(ST_OK, NO_SLOT, 32'd0, 40'd0, 9'd0)});
    dir_rows.push_back('{ACT_READ, 64'd0, 32'd0, 8'd0, 1'b1,
                         result_of(ST_RANGE, NO_SLOT, 32'd0, 40'd0, 9'd0)});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].child, dir_rows[i].idx,
                dir_rows[i].typed, dir_rows[i].res);

    phase = 0;
    n = sent_items;
    while (sent_items < n + RAND_ITEMS) begin
      // register writes only with the block idle and nothing in flight
      park();
      case (phase % 4)
        0:       cfg_val = '1;
        1:       cfg_val = '0;
        default: cfg_val = $urandom;
      endcase
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= cfg_val;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      leftmost_pg = cfg_val;
      gap_mode = $urandom_range(0, 2);
      if (phase == 1 || $urandom_range(0, 5) == 0) begin
        // fill to capacity, then probe the full table
        while (tbl_used < MAX_ENTRIES)
          send_item(ACT_INSERT, ({$urandom, $urandom} & KEY_LIMIT), $urandom,
                    RIDX_W'($urandom), 1'b0, no_res);
        send_item(ACT_INSERT, 64'd5, $urandom, RIDX_W'($urandom), 1'b1,
                  result_of(ST_FULL, NO_SLOT, 32'd0, 40'd0, 9'd256));
        send_item(ACT_INSERT, KEY_LIMIT + 64'd1, $urandom, RIDX_W'($urandom), 1'b1,
                  result_of(ST_WIDE, NO_SLOT, 32'd0, 40'd0, 9'd256));
        send_item(ACT_READ, 64'd0, 32'd0, 8'd255, 1'b0, no_res);
        repeat ($urandom_range(10, 30)) random_item();
      end else begin
        repeat ($urandom_range(30, 150)) random_item();
      end
      phase++;
    end

    park();
    repeat (12) @(posedge clk_i);
    if (err_count == 0) begin
      $display("sorted_separator_node_table_tb: PASS");
    end else begin
      $display("sorted_separator_node_table_tb: FAIL");
    end
    $finish;
  end

endmodule
